// ===== rtl/dvam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dvam_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int COORD_W    = 16;
    localparam int DIM_W      = 11;
    localparam int OFS_W      = 10;
    localparam int SHAPE_W    = 3;
    localparam int RAD_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int DELTA_W    = DIM_W + 2;
    localparam int SQ_W       = 2 * DELTA_W - 1;
    localparam int SUM_W      = SQ_W + 1;
    localparam int RSQ_W      = 2 * RAD_W;

    localparam int DIM_MAX_CODE = (1 << DIM_W) - 1;
    localparam logic [DIM_W-1:0] DIM_SAT =
        DIM_W'((MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM);

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_RECT    = 3'd0,
        SHAPE_CIRCLE  = 3'd1,
        SHAPE_ROUNDED = 3'd2,
        SHAPE_OCTAGON = 3'd3,
        SHAPE_CUSTOM  = 3'd4
    } t_shape;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PANEL_WIDTH  = 3'd0,
        CFG_PANEL_HEIGHT = 3'd1,
        CFG_SAFE_LEFT    = 3'd2,
        CFG_SAFE_TOP     = 3'd3,
        CFG_SAFE_SPAN_X  = 3'd4,
        CFG_SAFE_SPAN_Y  = 3'd5,
        CFG_PANEL_SHAPE  = 3'd6,
        CFG_CORNER_RAD   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [OFS_W-1:0]   safe_left;
        logic [OFS_W-1:0]   safe_top;
        logic [DIM_W-1:0]   span_x;
        logic [DIM_W-1:0]   span_y;
        logic [SHAPE_W-1:0] shape;
        logic [RAD_W-1:0]   rad;
    } t_cfg;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } t_adv;

    typedef struct packed {
        logic                      v;
        logic                      in_area;
        logic                      bypass;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
        logic [RAD_W-1:0]          r;
    } t_geom;

endpackage

`default_nettype wire

// ===== rtl/dvam_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dvam_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [dvam_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [dvam_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output dvam_pkg::t_cfg                      o_cfg
);
    import dvam_pkg::*;

    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [OFS_W-1:0]   r_safe_left;
    logic [OFS_W-1:0]   r_safe_top;
    logic [DIM_W-1:0]   r_span_x;
    logic [DIM_W-1:0]   r_span_y;
    logic [SHAPE_W-1:0] r_shape;
    logic [RAD_W-1:0]   r_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= DIM_W'(1024);
            r_height    <= DIM_W'(1024);
            r_safe_left <= '0;
            r_safe_top  <= '0;
            r_span_x    <= DIM_W'(1024);
            r_span_y    <= DIM_W'(1024);
            r_shape     <= SHAPE_RECT;
            r_rad       <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PANEL_WIDTH:  r_width     <= i_cfg_data[DIM_W-1:0];
                CFG_PANEL_HEIGHT: r_height    <= i_cfg_data[DIM_W-1:0];
                CFG_SAFE_LEFT:    r_safe_left <= i_cfg_data[OFS_W-1:0];
                CFG_SAFE_TOP:     r_safe_top  <= i_cfg_data[OFS_W-1:0];
                CFG_SAFE_SPAN_X:  r_span_x    <= i_cfg_data[DIM_W-1:0];
                CFG_SAFE_SPAN_Y:  r_span_y    <= i_cfg_data[DIM_W-1:0];
                CFG_PANEL_SHAPE:  r_shape     <= i_cfg_data[SHAPE_W-1:0];
                CFG_CORNER_RAD:   r_rad       <= i_cfg_data[RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate panel size to the largest supported dimension
    always_comb begin
        o_cfg.width     = (r_width > DIM_SAT) ? DIM_SAT : r_width;
        o_cfg.height    = (r_height > DIM_SAT) ? DIM_SAT : r_height;
        o_cfg.safe_left = r_safe_left;
        o_cfg.safe_top  = r_safe_top;
        o_cfg.span_x    = r_span_x;
        o_cfg.span_y    = r_span_y;
        o_cfg.shape     = r_shape;
        o_cfg.rad       = r_rad;
    end

endmodule

`default_nettype wire

// ===== rtl/dvam_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dvam_geom (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_en,
    input  wire logic                                i_valid,
    input  wire logic signed [dvam_pkg::COORD_W-1:0] i_x,
    input  wire logic signed [dvam_pkg::COORD_W-1:0] i_y,
    input  wire dvam_pkg::t_cfg                      i_cfg,
    output dvam_pkg::t_geom                          o_geom
);
    import dvam_pkg::*;

    localparam int LIM_W = DIM_W + 1;

    logic [COORD_W-1:0]        ux;
    logic [COORD_W-1:0]        uy;
    logic [LIM_W-1:0]          lim_x;
    logic [LIM_W-1:0]          lim_y;
    logic                      in_x;
    logic                      in_y;
    logic signed [DELTA_W-1:0] xs;
    logic signed [DELTA_W-1:0] ys;
    logic signed [DELTA_W-1:0] rs;
    logic signed [DELTA_W-1:0] wm;
    logic signed [DELTA_W-1:0] hm;
    logic signed [DELTA_W-1:0] cx;
    logic signed [DELTA_W-1:0] cy;
    logic                      side_x;
    logic                      side_y;
    logic [DIM_W-1:0]          min_dim;
    t_geom                     n_geom;
    t_geom                     r_geom;

    always_comb begin
        ux    = $unsigned(i_x);
        uy    = $unsigned(i_y);
        lim_x = LIM_W'(i_cfg.safe_left) + LIM_W'(i_cfg.span_x);
        lim_y = LIM_W'(i_cfg.safe_top) + LIM_W'(i_cfg.span_y);
        in_x  = !i_x[COORD_W-1]
                && (ux < COORD_W'(i_cfg.width))
                && (ux >= COORD_W'(i_cfg.safe_left))
                && (ux < COORD_W'(lim_x));
        in_y  = !i_y[COORD_W-1]
                && (uy < COORD_W'(i_cfg.height))
                && (uy >= COORD_W'(i_cfg.safe_top))
                && (uy < COORD_W'(lim_y));

        // only meaningful once the pixel is inside the panel
        xs = $signed({2'b00, ux[DIM_W-1:0]});
        ys = $signed({2'b00, uy[DIM_W-1:0]});
        rs = $signed(DELTA_W'(i_cfg.rad));
        wm = $signed({2'b00, i_cfg.width}) - rs;
        hm = $signed({2'b00, i_cfg.height}) - rs;

        side_x = 1'b1;
        if (xs < rs) begin
            cx = rs;
        end else if (xs >= wm) begin
            cx = wm - DELTA_W'(1);
        end else begin
            cx     = xs;
            side_x = 1'b0;
        end
        side_y = 1'b1;
        if (ys < rs) begin
            cy = rs;
        end else if (ys >= hm) begin
            cy = hm - DELTA_W'(1);
        end else begin
            cy     = ys;
            side_y = 1'b0;
        end

        min_dim = (i_cfg.width < i_cfg.height) ? i_cfg.width : i_cfg.height;

        n_geom.v       = i_valid;
        n_geom.in_area = in_x && in_y;
        case (t_shape'(i_cfg.shape))
            SHAPE_CIRCLE: begin
                n_geom.bypass = 1'b0;
                n_geom.dx     = xs - $signed({3'b000, i_cfg.width[DIM_W-1:1]});
                n_geom.dy     = ys - $signed({3'b000, i_cfg.height[DIM_W-1:1]});
                n_geom.r      = min_dim[DIM_W-1:1];
            end
            SHAPE_ROUNDED: begin
                n_geom.bypass = (i_cfg.rad == '0) || (!side_x && !side_y);
                n_geom.dx     = xs - cx;
                n_geom.dy     = ys - cy;
                n_geom.r      = i_cfg.rad;
            end
            default: begin
                n_geom.bypass = 1'b1;
                n_geom.dx     = xs;
                n_geom.dy     = ys;
                n_geom.r      = i_cfg.rad;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.v <= 1'b0;
        end else if (i_en) begin
            r_geom.v <= n_geom.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom.in_area <= n_geom.in_area;
            r_geom.bypass  <= n_geom.bypass;
            r_geom.dx      <= n_geom.dx;
            r_geom.dy      <= n_geom.dy;
            r_geom.r       <= n_geom.r;
        end
    end

    assign o_geom = r_geom;

endmodule

`default_nettype wire

// ===== rtl/dvam_dist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dvam_dist (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire dvam_pkg::t_adv  i_adv,
    input  wire dvam_pkg::t_geom i_geom,
    output logic                 o_sq_valid,
    output logic                 o_valid,
    output logic                 o_visible
);
    import dvam_pkg::*;

    logic signed [2*DELTA_W-1:0] n_dx_sq;
    logic signed [2*DELTA_W-1:0] n_dy_sq;
    logic [RSQ_W-1:0]            n_r_sq;
    logic                        r_sq_v;
    logic                        r_sq_in_area;
    logic                        r_sq_bypass;
    logic [SQ_W-1:0]             r_dx_sq;
    logic [SQ_W-1:0]             r_dy_sq;
    logic [RSQ_W-1:0]            r_r_sq;
    logic [SUM_W-1:0]            n_sum;
    logic                        n_visible;
    logic                        r_out_v;
    logic                        r_visible;

    always_comb begin
        n_dx_sq = i_geom.dx * i_geom.dx;
        n_dy_sq = i_geom.dy * i_geom.dy;
        n_r_sq  = RSQ_W'(i_geom.r) * RSQ_W'(i_geom.r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (i_adv.s3) begin
            r_sq_v <= i_geom.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s3) begin
            r_sq_in_area <= i_geom.in_area;
            r_sq_bypass  <= i_geom.bypass;
            r_dx_sq      <= n_dx_sq[SQ_W-1:0];
            r_dy_sq      <= n_dy_sq[SQ_W-1:0];
            r_r_sq       <= n_r_sq;
        end
    end

    always_comb begin
        n_sum     = SUM_W'(r_dx_sq) + SUM_W'(r_dy_sq);
        n_visible = r_sq_in_area && (r_sq_bypass || (n_sum <= SUM_W'(r_r_sq)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_adv.s4) begin
            r_out_v <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.s4) begin
            r_visible <= n_visible;
        end
    end

    assign o_sq_valid = r_sq_v;
    assign o_valid    = r_out_v;
    assign o_visible  = r_visible;

endmodule

`default_nettype wire

// ===== rtl/display_visible_area_mask.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------
// pixel in  | input     | i_valid / o_stall         | i_pix_x, i_pix_y (s16)
// result    | output    | o_valid / i_stall         | o_visible
// config    | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_stall is low; o_valid is the compare stage's register.
// Four register stages: input register, bounds and center stage, squaring stage, compare.
// Each stage advances when empty or when the stage after it advances, so
// bubbles close up under a stall and nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// Config writes are always ready.

module display_visible_area_mask (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [dvam_pkg::COORD_W-1:0] i_pix_x,
    input  wire logic signed [dvam_pkg::COORD_W-1:0] i_pix_y,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_visible,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [dvam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [dvam_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import dvam_pkg::*;

    t_cfg                      cfg;
    t_adv                      adv;
    t_geom                     geom;
    logic                      sq_valid;
    logic                      r_in_v;
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;

    dvam_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    always_comb begin
        adv.s4 = !i_stall || !o_valid;
        adv.s3 = adv.s4 || !sq_valid;
        adv.s2 = adv.s3 || !geom.v;
        adv.s1 = adv.s2 || !r_in_v;
    end

    assign o_stall     = !adv.s1;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (adv.s1) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv.s1) begin
            r_x <= i_pix_x;
            r_y <= i_pix_y;
        end
    end

    dvam_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv.s2),
        .i_valid (r_in_v),
        .i_x     (r_x),
        .i_y     (r_y),
        .i_cfg   (cfg),
        .o_geom  (geom)
    );

    dvam_dist u_dist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_geom     (geom),
        .o_sq_valid (sq_valid),
        .o_valid    (o_valid),
        .o_visible  (o_visible)
    );

endmodule

`default_nettype wire
